@@ src/chunked_bump_allocator_core_defines.svh @@
// Assertion macros for the chunk allocator checker.
`ifndef CHUNKED_BUMP_ALLOCATOR_CORE_DEFINES_SVH
`define CHUNKED_BUMP_ALLOCATOR_CORE_DEFINES_SVH

// Check a condition in the same cycle as its trigger.
`define CBA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cba check failed");

// Check a condition in the cycle after its trigger.
`define CBA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cba check failed");

`endif

@@ src/cba_pkg.sv @@
`timescale 1ns / 1ps
package cba_pkg;

  localparam int unsigned MAX_CHUNKS = 64;
  localparam int unsigned IDX_W      = $clog2(MAX_CHUNKS);
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned SIZE_W     = 25;
  localparam int unsigned OFF_W      = 24;

  localparam logic [SIZE_W-1:0] CHUNK_BYTES   = SIZE_W'(16777216);
  localparam logic [CNT_W-1:0]  INIT_RESET    = CNT_W'(10);
  localparam logic [CNT_W-1:0]  MAX_CHUNKS_C  = CNT_W'(MAX_CHUNKS);

  typedef enum logic [1:0] {
    ST_GRANTED   = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_NO_CHUNK  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_CUR,
    S_SCAN,
    S_OFFS,
    S_WRITE,
    S_DONE
  } state_e;

  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [SIZE_W-1:0] wr_data;
  } store_req_t;

endpackage

@@ src/cba_store.sv @@
`timescale 1ns / 1ps
module cba_store (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cba_pkg::store_req_t       req_i,
  output logic [cba_pkg::SIZE_W-1:0] rdata_o
);
  import cba_pkg::*;

  logic [SIZE_W-1:0]     mem [MAX_CHUNKS];
  logic [MAX_CHUNKS-1:0] vld_q;
  logic [SIZE_W-1:0]     rdata_q;
  logic                  rvld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (req_i.wr_en) begin
      vld_q[req_i.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q <= mem[req_i.rd_addr];
      rvld_q  <= vld_q[req_i.rd_addr];
    end
  end

  // unwritten entries read as a full chunk
  assign rdata_o = rvld_q ? rdata_q : CHUNK_BYTES;

endmodule

@@ src/cba_sub.sv @@
`timescale 1ns / 1ps
module cba_sub (
  input  logic [cba_pkg::SIZE_W-1:0] a_i,
  input  logic [cba_pkg::SIZE_W-1:0] b_i,
  output logic [cba_pkg::SIZE_W-1:0] diff_o,
  output logic                       ge_o
);
  import cba_pkg::*;

  logic [SIZE_W:0] full;

  assign full   = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = full[SIZE_W-1:0];
  assign ge_o   = ~full[SIZE_W];

endmodule

@@ src/chunked_bump_allocator_core.sv @@
`timescale 1ns / 1ps
// Chunked bump allocator. One input item is one request_size; one result item
// follows for each, with chunk_index, byte_offset, alloc_status, chunks_active.
// Both channels use valid/stall: an item moves when valid is high and stall low.
// Requests are handled one at a time; in_stall_o is high from acceptance until
// the result has been loaded into the output register, which then frees the
// input side even while the receiver still stalls the result.
// From the accepting edge, an oversized request goes from S_START to S_DONE;
// when the current chunk fits, it passes S_START, S_CUR, S_OFFS, S_WRITE and
// S_DONE. When the current chunk misses, S_SCAN reads chunk entries in turn
// until a fit or a new chunk, then goes on to S_OFFS (S_CUR is skipped when the
// current chunk lies outside the active set; when every chunk is full the request
// is refused straight from S_SCAN to S_DONE). The next item can be accepted in
// the cycle after the result loads. The scan length is set by the single read
// port of the chunk store and the one shared subtractor.
// A stalled result holds in the output register; the block finishes the next
// item and waits until that register empties.
// Reset: all chunks wholly free, no chunks grown, current chunk 0, initial_chunks 10.
// cfg_we_i writes initial_chunks; write it only while the block is idle.
module chunked_bump_allocator_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [cba_pkg::SIZE_W-1:0]      request_size_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [cba_pkg::IDX_W-1:0]       chunk_index_o,
  output logic [cba_pkg::OFF_W-1:0]       byte_offset_o,
  output logic [1:0]                      alloc_status_o,
  output logic [cba_pkg::CNT_W-1:0]       chunks_active_o,
  input  logic                            cfg_we_i,
  input  logic [cba_pkg::CNT_W-1:0]       cfg_wdata_i
);
  import cba_pkg::*;

  state_e            state_q, state_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [CNT_W-1:0]  act_q, act_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  pick_q, pick_d;
  logic [SIZE_W-1:0] free_q, free_d;
  logic [OFF_W-1:0]  off_q, off_d;
  logic              grow_q, grow_d;
  status_e           status_q, status_d;
  logic [IDX_W-1:0]  cur_q, cur_d;
  logic [CNT_W-1:0]  grown_q, grown_d;
  logic [CNT_W-1:0]  init_q;

  logic              out_valid_q, out_valid_d;
  logic [IDX_W-1:0]  out_idx_q;
  logic [OFF_W-1:0]  out_off_q;
  status_e           out_status_q;
  logic [CNT_W-1:0]  out_act_q;

  store_req_t        st_req;
  logic [SIZE_W-1:0] rdata;
  logic [SIZE_W-1:0] alu_a, alu_b, alu_diff;
  logic              alu_ge;

  logic [CNT_W-1:0]  init_cl;
  logic [CNT_W:0]    act_sum;
  logic [CNT_W-1:0]  active;
  logic              too_big, cur_in, more, full, load;

  cba_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (st_req),
    .rdata_o (rdata)
  );

  cba_sub u_sub (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .diff_o (alu_diff),
    .ge_o   (alu_ge)
  );

  always_comb begin
    if (init_q == '0) begin
      init_cl = CNT_W'(1);
    end else if (init_q > MAX_CHUNKS_C) begin
      init_cl = MAX_CHUNKS_C;
    end else begin
      init_cl = init_q;
    end
    act_sum = {1'b0, init_cl} + {1'b0, grown_q};
    active  = (act_sum > {1'b0, MAX_CHUNKS_C}) ? MAX_CHUNKS_C : act_sum[CNT_W-1:0];
  end

  assign too_big = size_q > CHUNK_BYTES;
  assign cur_in  = {1'b0, cur_q} < act_q;
  assign more    = ({1'b0, idx_q} + CNT_W'(1)) < act_q;
  assign full    = act_q >= MAX_CHUNKS_C;
  assign load    = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    unique case (state_q)
      S_OFFS: begin
        alu_a = CHUNK_BYTES;
        alu_b = free_q;
      end
      S_WRITE: begin
        alu_a = free_q;
        alu_b = size_q;
      end
      default: begin
        alu_a = rdata;
        alu_b = size_q;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_START;
      end
      S_START: begin
        if (too_big)     state_d = S_DONE;
        else if (cur_in) state_d = S_CUR;
        else             state_d = S_SCAN;
      end
      S_CUR: begin
        state_d = alu_ge ? S_OFFS : S_SCAN;
      end
      S_SCAN: begin
        priority if (alu_ge) state_d = S_OFFS;
        else if (more)       state_d = S_SCAN;
        else if (full)       state_d = S_DONE;
        else                 state_d = S_OFFS;
      end
      S_OFFS:  state_d = S_WRITE;
      S_WRITE: state_d = S_DONE;
      S_DONE: begin
        if (load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    size_d   = size_q;
    act_d    = act_q;
    idx_d    = idx_q;
    pick_d   = pick_q;
    free_d   = free_q;
    off_d    = off_q;
    grow_d   = grow_q;
    status_d = status_q;
    cur_d    = cur_q;
    grown_d  = grown_q;
    st_req   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          size_d   = (request_size_i == '0) ? SIZE_W'(1) : request_size_i;
          act_d    = active;
          grow_d   = 1'b0;
          status_d = ST_GRANTED;
        end
      end
      S_START: begin
        if (too_big) begin
          status_d = ST_TOO_LARGE;
          pick_d   = cur_q;
          off_d    = '0;
        end else if (cur_in) begin
          st_req.rd_en   = 1'b1;
          st_req.rd_addr = cur_q;
        end else begin
          st_req.rd_en   = 1'b1;
          st_req.rd_addr = '0;
          idx_d          = '0;
        end
      end
      S_CUR: begin
        if (alu_ge) begin
          pick_d = cur_q;
          free_d = rdata;
        end else begin
          st_req.rd_en   = 1'b1;
          st_req.rd_addr = '0;
          idx_d          = '0;
        end
      end
      S_SCAN: begin
        priority if (alu_ge) begin
          pick_d = idx_q;
          free_d = rdata;
        end else if (more) begin
          st_req.rd_en   = 1'b1;
          st_req.rd_addr = idx_q + IDX_W'(1);
          idx_d          = idx_q + IDX_W'(1);
        end else if (full) begin
          status_d = ST_NO_CHUNK;
          pick_d   = cur_q;
          off_d    = '0;
        end else begin
          pick_d = act_q[IDX_W-1:0];
          free_d = CHUNK_BYTES;
          grow_d = 1'b1;
        end
      end
      S_OFFS: begin
        off_d = alu_diff[OFF_W-1:0];
      end
      S_WRITE: begin
        st_req.wr_en   = 1'b1;
        st_req.wr_addr = pick_q;
        st_req.wr_data = alu_diff;
        cur_d          = pick_q;
        if (grow_q) grown_d = grown_q + CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign out_valid_d = load | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= '0;
      grown_q     <= '0;
      init_q      <= INIT_RESET;
      out_valid_q <= 1'b0;
      grow_q      <= 1'b0;
      status_q    <= ST_GRANTED;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      grown_q     <= grown_d;
      out_valid_q <= out_valid_d;
      grow_q      <= grow_d;
      status_q    <= status_d;
      if (cfg_we_i) init_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q <= size_d;
    act_q  <= act_d;
    idx_q  <= idx_d;
    pick_q <= pick_d;
    free_q <= free_d;
    off_q  <= off_d;
    if (load) begin
      out_idx_q    <= pick_q;
      out_off_q    <= off_q;
      out_status_q <= status_q;
      out_act_q    <= active;
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign chunk_index_o   = out_idx_q;
  assign byte_offset_o   = out_off_q;
  assign alloc_status_o  = out_status_q;
  assign chunks_active_o = out_act_q;

endmodule

@@ src/cba_checker.sv @@
`timescale 1ns / 1ps
`include "chunked_bump_allocator_core_defines.svh"
module cba_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic [cba_pkg::SIZE_W-1:0] request_size_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [cba_pkg::IDX_W-1:0]  chunk_index_o,
  input logic [cba_pkg::OFF_W-1:0]  byte_offset_o,
  input logic [1:0]                 alloc_status_o,
  input logic [cba_pkg::CNT_W-1:0]  chunks_active_o,
  input logic                       cfg_we_i,
  input logic [cba_pkg::CNT_W-1:0]  cfg_wdata_i
);
  import cba_pkg::*;

  `CBA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(chunk_index_o) && $stable(byte_offset_o) && $stable(alloc_status_o))

  `CBA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  `CBA_ASSERT_NOW(a_status_code, clk_i, rst_ni, out_valid_o, alloc_status_o != 2'd3)

  `CBA_ASSERT_NOW(a_active_range, clk_i, rst_ni, out_valid_o,
    chunks_active_o != '0 && chunks_active_o <= MAX_CHUNKS_C)

  `CBA_ASSERT_NOW(a_grant_in_active, clk_i, rst_ni, out_valid_o && alloc_status_o == ST_GRANTED,
    {1'b0, chunk_index_o} < chunks_active_o)

endmodule

bind chunked_bump_allocator_core cba_checker u_cba_checker (.*);

@@ sim/tb_chunked_bump_allocator_core.sv @@
`timescale 1ns / 1ps
module tb_chunked_bump_allocator_core;
  import cba_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [OFF_W-1:0] off;
    status_e          st;
    logic [CNT_W-1:0] act;
  } grant_t;

  class alloc_scoreboard;
    logic [SIZE_W-1:0] free_bytes [MAX_CHUNKS];
    logic [CNT_W-1:0]  grown;
    logic [CNT_W-1:0]  init_chunks;
    logic [IDX_W-1:0]  cur;
    grant_t            expected_grants[$];
    int unsigned       errors;
    int unsigned       n_granted;
    int unsigned       n_too_large;
    int unsigned       n_no_chunk;
    int unsigned       n_writes;

    function new();
      foreach (free_bytes[i]) free_bytes[i] = CHUNK_BYTES;
      grown = '0;
      cur = '0;
      init_chunks = INIT_RESET;
      errors = 0;
      n_granted = 0;
      n_too_large = 0;
      n_no_chunk = 0;
      n_writes = 0;
    endfunction

    function int unsigned active_chunks();
      int unsigned base;
      int unsigned total;
      base = init_chunks;
      if (base < 1) base = 1;
      if (base > MAX_CHUNKS) base = MAX_CHUNKS;
      total = base + grown;
      if (total > MAX_CHUNKS) total = MAX_CHUNKS;
      return total;
    endfunction

    function void write_initial(logic [CNT_W-1:0] v);
      init_chunks = v;
      n_writes++;
    endfunction

    function logic [SIZE_W-1:0] current_room();
      return free_bytes[cur];
    endfunction

    function int unsigned pending();
      return expected_grants.size();
    endfunction

    function void note_request(logic [SIZE_W-1:0] sz);
      int unsigned need;
      int unsigned act;
      int unsigned pick;
      bit          found;
      grant_t      g;
      need = (sz == 0) ? 1 : sz;
      act = active_chunks();
      g.idx = cur;
      g.off = '0;
      g.act = CNT_W'(act);
      if (need > CHUNK_BYTES) begin
        g.st = ST_TOO_LARGE;
        n_too_large++;
      end else begin
        found = 0;
        pick = 0;
        if (cur < act && free_bytes[cur] >= need) begin
          pick = cur;
          found = 1;
        end
        for (int i = 0; i < act && !found; i++) begin
          if (free_bytes[i] >= need) begin
            pick = i;
            found = 1;
          end
        end
        if (!found && act >= MAX_CHUNKS) begin
          g.st = ST_NO_CHUNK;
          n_no_chunk++;
        end else begin
          if (!found) begin
            pick = act;
            free_bytes[pick] = CHUNK_BYTES;
            grown = grown + 1'b1;
          end
          cur = IDX_W'(pick);
          g.idx = IDX_W'(pick);
          g.off = OFF_W'(CHUNK_BYTES - free_bytes[pick]);
          free_bytes[pick] = free_bytes[pick] - SIZE_W'(need);
          g.st = ST_GRANTED;
          g.act = CNT_W'(active_chunks());
          n_granted++;
        end
      end
      expected_grants.insert(expected_grants.size(), g);
    endfunction

    function void check_result(grant_t got);
      grant_t want;
      if (expected_grants.size() == 0) begin
        $error("unexpected result item: chunk_index %0d byte_offset %0d", got.idx, got.off);
        errors++;
        return;
      end
      want = expected_grants.pop_front();
      if (got.idx !== want.idx) begin
        $error("chunk_index: expected %0d, got %0d", want.idx, got.idx);
        errors++;
      end
      if (got.off !== want.off) begin
        $error("byte_offset: expected %0d, got %0d", want.off, got.off);
        errors++;
      end
      if (got.st !== want.st) begin
        $error("alloc_status: expected %0d, got %0d", want.st, got.st);
        errors++;
      end
      if (got.act !== want.act) begin
        $error("chunks_active: expected %0d, got %0d", want.act, got.act);
        errors++;
      end
    endfunction
  endclass

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [SIZE_W-1:0] request_size_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic [IDX_W-1:0]  chunk_index_o;
  logic [OFF_W-1:0]  byte_offset_o;
  logic [1:0]        alloc_status_o;
  logic [CNT_W-1:0]  chunks_active_o;
  logic              cfg_we_i;
  logic [CNT_W-1:0]  cfg_wdata_i;

  alloc_scoreboard ledger;
  grant_t          seen;
  bit              steady;
  int unsigned     n_sent;

  chunked_bump_allocator_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .request_size_i  (request_size_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .chunk_index_o   (chunk_index_o),
    .byte_offset_o   (byte_offset_o),
    .alloc_status_o  (alloc_status_o),
    .chunks_active_o (chunks_active_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    out_stall_i = 1'b0;
    forever @(negedge clk_i) out_stall_i <= !steady && ($urandom_range(99) < 36);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen.idx = chunk_index_o;
      seen.off = byte_offset_o;
      seen.st  = status_e'(alloc_status_o);
      seen.act = chunks_active_o;
      ledger.check_result(seen);
    end
  end

  task automatic send_request(input logic [SIZE_W-1:0] sz);
    while (!steady && $urandom_range(99) < 36) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    request_size_i <= sz;
    do @(posedge clk_i); while (in_stall_o);
    ledger.note_request(sz);
    n_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_initial_chunks(input logic [CNT_W-1:0] v);
    in_valid_i <= 1'b0;
    while (ledger.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    ledger.write_initial(v);
  endtask

  function automatic logic [SIZE_W-1:0] draw_request_size(input bit heavy);
    int unsigned       r;
    int unsigned       w;
    logic [31:0]       mask;
    logic [SIZE_W-1:0] room;
    r = $urandom_range(99);
    room = ledger.current_room();
    if (r < (heavy ? 25 : 8)) return (room == 0) ? SIZE_W'(1) : room;
    if (r < (heavy ? 30 : 11)) return room + 1'b1;
    if (r < (heavy ? 33 : 14)) begin
      case ($urandom_range(3))
        0: return '0;
        1: return CHUNK_BYTES;
        2: return CHUNK_BYTES + 1'b1 + SIZE_W'($urandom_range(1000));
        default: return '1;
      endcase
    end
    if (heavy) w = ($urandom_range(99) < 60) ? $urandom_range(25, 20) : $urandom_range(25, 1);
    else w = ($urandom_range(99) < 85) ? $urandom_range(20, 1) : $urandom_range(25, 21);
    mask = (32'd1 << w) - 1;
    return SIZE_W'($urandom & mask);
  endfunction

  initial begin
    logic [CNT_W-1:0] phase_init [8];
    bit               phase_heavy [8];
    ledger = new();
    steady = 1'b0;
    n_sent = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    request_size_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    phase_init = '{CNT_W'(64), CNT_W'(127), CNT_W'(10), CNT_W'(0), CNT_W'(1),
                   CNT_W'($urandom_range(127)), CNT_W'(65), CNT_W'(33)};
    phase_heavy = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0};
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_request('0);
    send_request(SIZE_W'(1));
    send_request('1);
    send_request(CHUNK_BYTES + 1'b1);
    send_request(CHUNK_BYTES);
    send_request(CHUNK_BYTES - 2'd2);
    send_request(SIZE_W'(1));
    write_initial_chunks(CNT_W'(0));
    send_request(SIZE_W'(5));
    send_request(SIZE_W'(25'h0AA_AAAA));
    write_initial_chunks(CNT_W'(127));
    send_request(CHUNK_BYTES);
    send_request(SIZE_W'(25'h155_5555));
    send_request(SIZE_W'(25'h055_5555));
    write_initial_chunks(CNT_W'(64));
    send_request(SIZE_W'(3));
    send_request(CHUNK_BYTES);
    write_initial_chunks(CNT_W'(1));
    send_request(SIZE_W'(7));
    send_request(CHUNK_BYTES);

    for (int p = 0; p < 8; p++) begin
      write_initial_chunks(phase_init[p]);
      steady = (p == 2);
      repeat (241) send_request(draw_request_size(phase_heavy[p]));
    end
    steady = 1'b0;

    in_valid_i <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    $display("Sent %0d requests under %0d register writes.", n_sent, ledger.n_writes);
    $display("Expected %0d grants, %0d oversized refusals, %0d out-of-chunk refusals.",
             ledger.n_granted, ledger.n_too_large, ledger.n_no_chunk);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+src
src/cba_pkg.sv
src/cba_store.sv
src/cba_sub.sv
src/chunked_bump_allocator_core.sv
src/cba_checker.sv
sim/tb_chunked_bump_allocator_core.sv
